>>> rtl/kpc_pkg.sv
// kpc_pkg: shared types, constants and helper functions of the keyed polybius cipher unit
// no dependencies; every rtl file imports it
package kpc_pkg;

  localparam int SQUARE_DEPTH  = 256;
  localparam int ALPHABET_SIZE = 94;
  localparam int SQ_AW         = $clog2(SQUARE_DEPTH);
  localparam int FILL_W        = 9;
  localparam int CHAR_W        = 7;
  localparam int CHAR_COUNT    = 128;
  localparam int QUEUE_DEPTH   = 2;
  localparam int Q_AW          = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_DECRYPT = 2'd2;

  // input operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_ALPHA = 2'd2;
  localparam logic [1:0] OP_TEXT  = 2'd3;

  // classified commands for the back end
  localparam logic [2:0] CMD_CLEAR     = 3'd0;
  localparam logic [2:0] CMD_KEY       = 3'd1;
  localparam logic [2:0] CMD_ALPHA     = 3'd2;
  localparam logic [2:0] CMD_ENC_WS    = 3'd3;
  localparam logic [2:0] CMD_ENC_NL    = 3'd4;
  localparam logic [2:0] CMD_ENC_CHAR  = 3'd5;
  localparam logic [2:0] CMD_DEC_WS    = 3'd6;
  localparam logic [2:0] CMD_DEC_DIGIT = 3'd7;

  localparam logic [CHAR_W-1:0] CH_TAB     = 7'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 7'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CH_A_UPPER = 7'd65;
  localparam logic [CHAR_W-1:0] HEX_ALPHA  = 7'd55;

  typedef struct packed {
    logic [1:0]        op;
    logic [CHAR_W-1:0] char_in;
  } kpc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              bad_char;
    logic              last;
  } kpc_out_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [CHAR_W-1:0] ch;
    logic [3:0]        digit;
  } kpc_cmd_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    return (d < 4'd10) ? (CH_ZERO + dx) : (HEX_ALPHA + dx);
  endfunction

  function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = (c < CH_A_UPPER) ? (c - CH_ZERO) : (c - HEX_ALPHA);
    return v[3:0];
  endfunction

endpackage

>>> rtl/keyed_polybius_cipher_unit.sv
// keyed_polybius_cipher_unit: top level with config registers, front end, queue and back end;
//   depends on kpc_pkg, kpc_front, kpc_queue, kpc_back
// loading items give no result; echoes and bad chars go to the output register, an encrypted
//   char reads the position map and then emits its two digits, and a column digit in decrypt
//   mode is reduced modulo columns, then the square is read; a new command is taken only in
//   the idle state; synchronous rst_n clears control state only, not memories or data registers
module keyed_polybius_cipher_unit import kpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kpc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kpc_out_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [3:0] cfg_wdata
);

  logic [3:0] rows_r;
  logic [3:0] columns_r;
  logic       decrypt_r;

  logic     push_valid;
  logic     push_ready;
  kpc_cmd_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  kpc_cmd_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 4'd10;
      columns_r <= 4'd10;
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS:    rows_r    <= cfg_wdata;
        REG_COLUMNS: columns_r <= cfg_wdata;
        REG_DECRYPT: decrypt_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  kpc_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .decrypt_mode (decrypt_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  kpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  kpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .rows      (rows_r),
    .columns   (columns_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/kpc_front.sv
// kpc_front: accepts input items and classifies them into back end commands
// depends on kpc_pkg
module kpc_front import kpc_pkg::*; (
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kpc_in_t  in_data,
  input  logic     decrypt_mode,
  output logic     push_valid,
  input  logic     push_ready,
  output kpc_cmd_t push_data
);

  logic is_ws;
  logic is_nl;

  assign is_nl = (in_data.char_in == CH_NL);
  assign is_ws = (in_data.char_in == CH_SPACE) || (in_data.char_in == CH_TAB);

  always_comb begin
    push_data.ch    = in_data.char_in;
    push_data.digit = digit_value(in_data.char_in);
    case (in_data.op)
      OP_CLEAR: push_data.cmd = CMD_CLEAR;
      OP_KEY:   push_data.cmd = CMD_KEY;
      OP_ALPHA: push_data.cmd = CMD_ALPHA;
      default: begin
        if (decrypt_mode) begin
          push_data.cmd = (is_ws || is_nl) ? CMD_DEC_WS : CMD_DEC_DIGIT;
        end else if (is_ws) begin
          push_data.cmd = CMD_ENC_WS;
        end else if (is_nl) begin
          push_data.cmd = CMD_ENC_NL;
        end else begin
          push_data.cmd = CMD_ENC_CHAR;
        end
      end
    endcase
  end

  assign push_valid = in_valid && rst_n;
  assign in_ready   = push_ready && rst_n;

endmodule

>>> rtl/kpc_queue.sv
// kpc_queue: short command queue between the front and back ends
// depends on kpc_pkg
module kpc_queue import kpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  kpc_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output kpc_cmd_t pop_data
);

  kpc_cmd_t         entry_r [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != (Q_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/kpc_back.sv
// kpc_back: executes commands; holds the square, position map, pairing state and output register
// depends on kpc_pkg
module kpc_back import kpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  kpc_cmd_t q_data,
  input  logic [3:0] rows,
  input  logic [3:0] columns,
  output logic     out_valid,
  input  logic     out_ready,
  output kpc_out_t out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EMIT1 = 3'd1;
  localparam logic [2:0] ST_EMIT2 = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_SQ    = 3'd4;

  logic [CHAR_W-1:0] square_mem [SQUARE_DEPTH];
  logic [7:0]        pos_mem    [CHAR_COUNT];
  logic [CHAR_W-1:0] sq_rd_r;
  logic [7:0]        pos_rd_r;

  logic [2:0]            state_r, state_nxt;
  logic [CHAR_COUNT-1:0] present_r, present_nxt;
  logic [CHAR_COUNT-1:0] legal_r, legal_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [3:0]            nrow_r, nrow_nxt;
  logic [3:0]            ncol_r, ncol_nxt;
  logic [3:0]            prow_r, prow_nxt;
  logic                  phase_r, phase_nxt;
  logic [3:0]            col_r, col_nxt;
  logic                  hit_r, hit_nxt;
  logic [CHAR_W-1:0]     second_r, second_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kpc_out_t              out_data_r, out_data_nxt;

  logic              out_free;
  logic              emit;
  kpc_out_t          emit_data;
  logic              do_append;
  logic              full;
  logic [7:0]        limit;
  logic [7:0]        idx;
  logic [3:0]        ncol_inc;
  logic              sq_we, sq_re, pos_we, pos_re;
  logic [CHAR_W-1:0] c;

  assign c        = q_data.ch;
  assign out_free = !out_valid_r || out_ready;
  assign limit    = {4'b0000, rows} * {4'b0000, columns};
  assign full     = (fill_r >= {1'b0, limit}) || (fill_r >= FILL_W'(SQUARE_DEPTH));
  assign idx      = ({4'b0000, prow_r} * {4'b0000, columns}) + {4'b0000, col_r};
  assign ncol_inc = ncol_r + 4'd1;

  always_comb begin
    state_nxt   = state_r;
    present_nxt = present_r;
    legal_nxt   = legal_r;
    fill_nxt    = fill_r;
    nrow_nxt    = nrow_r;
    ncol_nxt    = ncol_r;
    prow_nxt    = prow_r;
    phase_nxt   = phase_r;
    col_nxt     = col_r;
    hit_nxt     = hit_r;
    second_nxt  = second_r;
    q_ready     = 1'b0;
    do_append   = 1'b0;
    sq_re       = 1'b0;
    pos_re      = 1'b0;
    emit        = 1'b0;
    emit_data   = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_data.cmd)
            CMD_CLEAR: begin
              q_ready     = 1'b1;
              present_nxt = '0;
              legal_nxt   = '0;
              fill_nxt    = '0;
              nrow_nxt    = '0;
              ncol_nxt    = '0;
              prow_nxt    = '0;
              phase_nxt   = 1'b0;
            end
            CMD_KEY: begin
              q_ready   = 1'b1;
              do_append = 1'b1;
            end
            CMD_ALPHA: begin
              q_ready      = 1'b1;
              legal_nxt[c] = 1'b1;
              do_append    = !present_r[c];
            end
            CMD_ENC_WS: begin
              if (out_free) begin
                q_ready   = 1'b1;
                emit      = 1'b1;
                emit_data = '{char_out: c, bad_char: 1'b0, last: 1'b1};
              end
            end
            CMD_ENC_NL: begin
              if (out_free) begin
                q_ready    = 1'b1;
                emit       = 1'b1;
                emit_data  = '{char_out: CH_SPACE, bad_char: 1'b0, last: 1'b0};
                second_nxt = CH_NL;
                state_nxt  = ST_EMIT2;
              end
            end
            CMD_ENC_CHAR: begin
              if (!(legal_r[c] && present_r[c])) begin
                if (out_free) begin
                  q_ready   = 1'b1;
                  emit      = 1'b1;
                  emit_data = '{char_out: '0, bad_char: 1'b1, last: 1'b1};
                end
              end else begin
                // position map read lands in pos_rd_r for the next state
                q_ready   = 1'b1;
                pos_re    = 1'b1;
                state_nxt = ST_EMIT1;
              end
            end
            CMD_DEC_WS: begin
              if (out_free) begin
                q_ready   = 1'b1;
                emit      = 1'b1;
                emit_data = '{char_out: c, bad_char: 1'b0, last: 1'b1};
                phase_nxt = 1'b0;
                prow_nxt  = '0;
              end
            end
            CMD_DEC_DIGIT: begin
              q_ready = 1'b1;
              if (!phase_r) begin
                prow_nxt  = q_data.digit;
                phase_nxt = 1'b1;
              end else begin
                col_nxt   = (columns == 4'd0) ? 4'd0 : q_data.digit;
                state_nxt = ST_MOD;
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT1: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = '{char_out: hex_char(pos_rd_r[7:4]), bad_char: 1'b0, last: 1'b0};
          second_nxt = hex_char(pos_rd_r[3:0]);
          state_nxt  = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{char_out: second_r, bad_char: 1'b0, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        // column modulo by repeated subtraction, one step a cycle
        if ((columns != 4'd0) && (col_r >= columns)) begin
          col_nxt = col_r - columns;
        end else begin
          sq_re     = 1'b1;
          hit_nxt   = ({1'b0, idx} < fill_r) && ({1'b0, idx} < FILL_W'(SQUARE_DEPTH));
          phase_nxt = 1'b0;
          prow_nxt  = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{char_out: hit_r ? sq_rd_r : '0, bad_char: 1'b0, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    sq_we  = do_append && !full;
    pos_we = sq_we && !present_r[c];
    if (sq_we) begin
      present_nxt[c] = 1'b1;
      fill_nxt       = fill_r + 1'b1;
      if (ncol_inc >= columns) begin
        ncol_nxt = '0;
        nrow_nxt = nrow_r + 4'd1;
      end else begin
        ncol_nxt = ncol_inc;
      end
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      legal_r     <= '0;
      fill_r      <= '0;
      nrow_r      <= '0;
      ncol_r      <= '0;
      prow_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      legal_r     <= legal_nxt;
      fill_r      <= fill_nxt;
      nrow_r      <= nrow_nxt;
      ncol_r      <= ncol_nxt;
      prow_r      <= prow_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    hit_r      <= hit_nxt;
    second_r   <= second_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (sq_we) begin
      square_mem[fill_r[SQ_AW-1:0]] <= c;
    end
    if (sq_re) begin
      sq_rd_r <= square_mem[idx[SQ_AW-1:0]];
    end
    if (pos_we) begin
      pos_mem[c] <= {nrow_r, ncol_r};
    end
    if (pos_re) begin
      pos_rd_r <= pos_mem[c];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/kpc_checker.sv
// kpc_checker: port level checks of the keyed polybius cipher unit, bound to the top level
// depends on kpc_pkg and keyed_polybius_cipher_unit
module kpc_checker import kpc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input kpc_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input kpc_out_t out_data
);

  // a stalled input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a bad character ends the results of its item
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_char |-> out_data.last)
    else $error("bad_char without last");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_char |-> (out_data.char_out == '0))
    else $error("bad_char with nonzero char_out");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyed_polybius_cipher_unit kpc_checker u_kpc_checker (.*);

>>> test/tb_top.sv
// tb_top: self-checking testbench for keyed_polybius_cipher_unit
// depends on kpc_pkg and the rtl; a directed table runs first, then random load/text phases,
// results checked against typed table entries or an in-bench model of the keyed square
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kpc_pkg::*;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;

  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
  localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;
  localparam logic [CHAR_W-1:0] CH_A   = 7'h41;
  localparam logic [CHAR_W-1:0] CH_K   = 7'h4B;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        code;
    logic [CHAR_W-1:0] val;
    int                n_typed;
    kpc_out_t          r0;
    kpc_out_t          r1;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  kpc_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  kpc_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_addr  = REG_ROWS;
  logic [3:0]        cfg_wdata = '0;

  // square model
  logic [CHAR_W-1:0] sq_mem  [SQUARE_DEPTH];
  logic [7:0]        pos_mem [CHAR_COUNT];
  logic [127:0]      placed    = '0;
  logic [127:0]      legal     = '0;
  int unsigned       fill      = 0;
  logic [3:0]        nrow      = '0;
  logic [3:0]        ncol      = '0;
  logic [3:0]        prow      = '0;
  bit                col_next  = 1'b0;
  logic [3:0]        cfg_rows  = 4'd10;
  logic [3:0]        cfg_cols  = 4'd10;
  bit                cfg_dec   = 1'b0;

  kpc_out_t          expected_chars[$];
  stim_row_t         stim_table[$];
  logic [CHAR_W-1:0] alpha_list[$];

  bit tx_gaps       = 1'b1;
  bit rx_gaps       = 1'b1;
  bit long_hold_req = 1'b0;
  int errors        = 0;
  int sent          = 0;
  int quiet_cycles  = 0;

  keyed_polybius_cipher_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic kpc_out_t res(logic [CHAR_W-1:0] ch, logic bad, logic fin);
    kpc_out_t r;
    r.char_out = ch;
    r.bad_char = bad;
    r.last     = fin;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_upper(logic [3:0] d);
    string digits;
    digits = "0123456789ABCDEF";
    return 7'(digits[d]);
  endfunction

  function automatic logic [3:0] digit_of(logic [CHAR_W-1:0] c);
    int v;
    v = (c < 7'd65) ? int'(c) - 48 : int'(c) - 55;
    return v[3:0];
  endfunction

  function automatic void sq_append(logic [CHAR_W-1:0] c);
    int unsigned cap;
    cap = int'(cfg_rows) * int'(cfg_cols);
    if (fill >= cap || fill >= SQUARE_DEPTH) return;
    sq_mem[fill] = c;
    // position map keeps the first placement only
    if (!placed[c]) begin
      placed[c] = 1'b1;
      pos_mem[c] = {nrow, ncol};
    end
    fill++;
    ncol = ncol + 4'd1;
    if (ncol >= cfg_cols) begin
      ncol = '0;
      nrow = nrow + 4'd1;
    end
  endfunction

  // advances the model by one accepted transaction, queues its results when push is set
  function automatic void predict_cipher(kpc_in_t it, bit push);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] ch;
    logic [3:0]        v;
    int                col;
    int                idx;
    kpc_out_t          outs[$];
    c = it.char_in;
    case (it.op)
      OP_CLEAR: begin
        placed   = '0;
        legal    = '0;
        fill     = 0;
        nrow     = '0;
        ncol     = '0;
        prow     = '0;
        col_next = 1'b0;
      end
      OP_KEY: sq_append(c);
      OP_ALPHA: begin
        legal[c] = 1'b1;
        if (!placed[c]) sq_append(c);
      end
      default: begin
        if (!cfg_dec) begin
          if (c == CH_SPACE || c == CH_TAB) begin
            outs.push_back(res(c, 1'b0, 1'b1));
          end else if (c == CH_NL) begin
            outs.push_back(res(CH_SPACE, 1'b0, 1'b0));
            outs.push_back(res(CH_NL, 1'b0, 1'b1));
          end else if (!legal[c] || !placed[c]) begin
            outs.push_back(res('0, 1'b1, 1'b1));
          end else begin
            outs.push_back(res(hex_upper(pos_mem[c][7:4]), 1'b0, 1'b0));
            outs.push_back(res(hex_upper(pos_mem[c][3:0]), 1'b0, 1'b1));
          end
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
          col_next = 1'b0;
          prow     = '0;
          outs.push_back(res(c, 1'b0, 1'b1));
        end else begin
          v = digit_of(c);
          if (!col_next) begin
            prow     = v;
            col_next = 1'b1;
          end else begin
            col = (cfg_cols != 0) ? int'(v) % int'(cfg_cols) : 0;
            idx = int'(prow) * int'(cfg_cols) + col;
            ch  = (idx < int'(fill) && idx < SQUARE_DEPTH) ? sq_mem[idx] : '0;
            col_next = 1'b0;
            prow     = '0;
            outs.push_back(res(ch, 1'b0, 1'b1));
          end
        end
      end
    endcase
    if (push) foreach (outs[i]) expected_chars.push_back(outs[i]);
  endfunction

  function automatic void add_row(row_kind_t kind, logic [1:0] code, logic [CHAR_W-1:0] val,
                                  int n_typed = -1, kpc_out_t r0 = '0, kpc_out_t r1 = '0);
    stim_row_t row;
    row.kind    = kind;
    row.code    = code;
    row.val     = val;
    row.n_typed = n_typed;
    row.r0      = r0;
    row.r1      = r1;
    stim_table.push_back(row);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_space();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // hex digit, letters sometimes in lower case
  function automatic logic [CHAR_W-1:0] rand_hex(logic [3:0] d);
    logic [CHAR_W-1:0] c;
    c = hex_upper(d);
    if (d > 4'd9 && $urandom_range(0, 1) == 1) c = c + 7'd32;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
    errors++;
    if (errors <= 100) $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic check_result(kpc_out_t got);
    kpc_out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("result with nothing expected", got.char_out, '0);
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_out !== want.char_out) report_mismatch("char_out", got.char_out, want.char_out);
    if (got.bad_char !== want.bad_char)
      report_mismatch("bad_char", 7'(got.bad_char), 7'(want.bad_char));
    if (got.last !== want.last) report_mismatch("last", 7'(got.last), 7'(want.last));
  endtask

  task automatic send_item(logic [1:0] op, logic [CHAR_W-1:0] c, bit push);
    kpc_in_t it;
    int      gap;
    it.op      = op;
    it.char_in = c;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_cipher(it, push);
    sent++;
  endtask

  // loading items give no result, so give the block time to finish them too
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ROWS:    cfg_rows = val;
      REG_COLUMNS: cfg_cols = val;
      REG_DECRYPT: cfg_dec  = val[0];
      default: ;
    endcase
  endtask

  task automatic load_square();
    int                nkeys;
    int                nalpha;
    logic [CHAR_W-1:0] c;
    send_item(OP_CLEAR, 7'($urandom), 1'b1);
    alpha_list.delete();
    nkeys = $urandom_range(0, 8);
    repeat (nkeys) begin
      c = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(33, 126));
      send_item(OP_KEY, c, 1'b1);
    end
    if ($urandom_range(0, 2) == 0) begin
      // full printable alphabet in order
      for (int k = 33; k < 33 + ALPHABET_SIZE; k++) begin
        send_item(OP_ALPHA, 7'(k), 1'b1);
        alpha_list.push_back(7'(k));
      end
    end else begin
      nalpha = $urandom_range(1, 40);
      repeat (nalpha) begin
        c = 7'($urandom);
        send_item(OP_ALPHA, c, 1'b1);
        alpha_list.push_back(c);
      end
    end
  endtask

  // receiving side
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 9) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", quiet_cycles);
      $display("FAIL keyed_polybius_cipher_unit");
      $finish;
    end
  end

  initial begin
    int                ph;
    int                ntext;
    int                pick;
    int                base;
    logic [3:0]        rows_v;
    logic [3:0]        cols_v;
    logic [3:0]        rdig;
    logic [3:0]        cdig;
    bit                dec_v;
    logic [CHAR_W-1:0] c;

    // after reset: nothing loaded, whitespace echoed
    add_row(ROW_ITEM, OP_TEXT, CH_A, 1, res('0, 1'b1, 1'b1));
    add_row(ROW_ITEM, OP_TEXT, CH_SPACE, 1, res(CH_SPACE, 1'b0, 1'b1));
    add_row(ROW_ITEM, OP_TEXT, CH_TAB, 1, res(CH_TAB, 1'b0, 1'b1));
    add_row(ROW_ITEM, OP_TEXT, CH_NL, 2, res(CH_SPACE, 1'b0, 1'b0), res(CH_NL, 1'b0, 1'b1));
    // 1x3 square, filled by a repeated key char and the alphabet
    add_row(ROW_CFG, REG_ROWS, 7'd1);
    add_row(ROW_CFG, REG_COLUMNS, 7'd3);
    add_row(ROW_ITEM, OP_CLEAR, 7'h2A);
    add_row(ROW_ITEM, OP_KEY, CH_K);
    add_row(ROW_ITEM, OP_KEY, CH_K);
    add_row(ROW_ITEM, OP_ALPHA, CH_NUL);
    add_row(ROW_ITEM, OP_ALPHA, CH_A);
    add_row(ROW_ITEM, OP_ALPHA, CH_K);
    add_row(ROW_ITEM, OP_ALPHA, CH_DEL);
    add_row(ROW_ITEM, OP_TEXT, CH_K, 2, res(CH_ZERO, 1'b0, 1'b0), res(CH_ZERO, 1'b0, 1'b1));
    // legal but square already full
    add_row(ROW_ITEM, OP_TEXT, CH_A, 1, res('0, 1'b1, 1'b1));
    add_row(ROW_ITEM, OP_TEXT, CH_NUL);
    add_row(ROW_ITEM, OP_TEXT, CH_DEL, 1, res('0, 1'b1, 1'b1));
    // decrypt: pairs, non-hex digits, whitespace breaking a pair
    add_row(ROW_CFG, REG_DECRYPT, 7'd1);
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd0));
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd2));
    add_row(ROW_ITEM, OP_TEXT, CH_DEL);
    add_row(ROW_ITEM, OP_TEXT, CH_NL, 1, res(CH_NL, 1'b0, 1'b1));
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd15));
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd15));
    add_row(ROW_CFG, REG_COLUMNS, 7'd15);
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd0));
    add_row(ROW_ITEM, OP_TEXT, CH_NUL);
    // zero columns, and clear dropping a pending row digit
    add_row(ROW_CFG, REG_COLUMNS, 7'd0);
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd5));
    add_row(ROW_ITEM, OP_CLEAR, 7'h55);
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd3));
    add_row(ROW_ITEM, OP_TEXT, hex_upper(4'd9));

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(stim_table[i].code, stim_table[i].val[3:0]);
      end else begin
        send_item(stim_table[i].code, stim_table[i].val, stim_table[i].n_typed < 0);
        if (stim_table[i].n_typed > 0) expected_chars.push_back(stim_table[i].r0);
        if (stim_table[i].n_typed > 1) expected_chars.push_back(stim_table[i].r1);
      end
    end

    base = sent;
    ph = 0;
    while (sent - base < RANDOM_ITEMS) begin
      settle_idle();
      case (ph)
        0: begin rows_v = 4'd15; cols_v = 4'd15; dec_v = 1'b0; end
        1: begin rows_v = 4'd1;  cols_v = 4'd1;  dec_v = 1'b1; end
        2: begin rows_v = 4'd15; cols_v = 4'd1;  dec_v = 1'b0; end
        3: begin rows_v = 4'd1;  cols_v = 4'd15; dec_v = 1'b1; end
        default: begin
          rows_v = 4'($urandom_range(1, 15));
          cols_v = 4'($urandom_range(1, 15));
          dec_v  = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_ROWS, rows_v);
      write_reg(REG_COLUMNS, cols_v);
      write_reg(REG_DECRYPT, {3'b000, dec_v});
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      // receiver stops for a long stretch so the block backs up into its input
      if (ph == 2) long_hold_req = 1'b1;
      // some phases keep the old square so recorded positions outlive a register change
      if (ph < 4 || $urandom_range(0, 3) != 0) load_square();
      ntext = $urandom_range(60, 140);
      for (int n = 0; n < ntext; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_item(2'($urandom), 7'($urandom), 1'b1);
        end else if (!cfg_dec) begin
          if (pick < 15 && alpha_list.size() > 0)
            c = alpha_list[$urandom_range(0, alpha_list.size() - 1)];
          else if (pick < 17)
            c = rand_space();
          else
            c = 7'($urandom);
          send_item(OP_TEXT, c, 1'b1);
        end else if (pick < 14) begin
          rdig = (pick < 12) ? 4'($urandom_range(0, int'(cfg_rows) - 1)) : 4'($urandom);
          cdig = 4'($urandom);
          send_item(OP_TEXT, rand_hex(rdig), 1'b1);
          send_item(OP_TEXT, rand_hex(cdig), 1'b1);
        end else if (pick < 17) begin
          send_item(OP_TEXT, rand_space(), 1'b1);
        end else begin
          send_item(OP_TEXT, 7'($urandom), 1'b1);
        end
      end
      ph++;
    end

    settle_idle();
    if (errors == 0) begin
      $display("PASS keyed_polybius_cipher_unit");
    end else begin
      $display("FAIL keyed_polybius_cipher_unit");
    end
    $finish;
  end

endmodule
